FILE: hw/rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg: shared types and constants of the path expression tokenizer
// Parse modes, error codes, character codes and the index control bundle.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int DEFAULT_INDEX_BITS = 32;
  localparam int MODE_W = 4;
  localparam int ERR_W  = 4;
  localparam int CHAR_W = 8;
  localparam int OUT_INDEX_W = 32;

  // Parse modes
  localparam logic [MODE_W-1:0] M_DOLLAR      = 4'd0;
  localparam logic [MODE_W-1:0] M_STEP        = 4'd1;
  localparam logic [MODE_W-1:0] M_DOT_FIRST   = 4'd2;
  localparam logic [MODE_W-1:0] M_DOT_REST    = 4'd3;
  localparam logic [MODE_W-1:0] M_BR_OPEN     = 4'd4;
  localparam logic [MODE_W-1:0] M_WILD_CLOSE  = 4'd5;
  localparam logic [MODE_W-1:0] M_QUOTED      = 4'd6;
  localparam logic [MODE_W-1:0] M_QUOTED_ESC  = 4'd7;
  localparam logic [MODE_W-1:0] M_QUOTE_CLOSE = 4'd8;
  localparam logic [MODE_W-1:0] M_INDEX       = 4'd9;
  localparam logic [MODE_W-1:0] M_SWALLOW     = 4'd10;

  // Error codes
  localparam logic [ERR_W-1:0] E_OK          = 4'd0;
  localparam logic [ERR_W-1:0] E_NO_DOLLAR   = 4'd1;
  localparam logic [ERR_W-1:0] E_BAD_DOT     = 4'd2;
  localparam logic [ERR_W-1:0] E_OPEN_BR     = 4'd3;
  localparam logic [ERR_W-1:0] E_BAD_WILD    = 4'd4;
  localparam logic [ERR_W-1:0] E_ESC_END     = 4'd5;
  localparam logic [ERR_W-1:0] E_BAD_ESC     = 4'd6;
  localparam logic [ERR_W-1:0] E_OPEN_QUOTE  = 4'd7;
  localparam logic [ERR_W-1:0] E_QUOTE_CLOSE = 4'd8;
  localparam logic [ERR_W-1:0] E_INDEX_CLOSE = 4'd9;
  localparam logic [ERR_W-1:0] E_BAD_BRACKET = 4'd10;
  localparam logic [ERR_W-1:0] E_BAD_SYNTAX  = 4'd11;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LBR    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBR    = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LOW_R  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

  localparam int DIGIT_W = 4;
  localparam int RADIX   = 10;

  // Index accumulator control from the parser
  typedef struct packed {
    logic               start;  // first digit: clear before adding
    logic               add;    // fold one digit into the accumulator
    logic [DIGIT_W-1:0] digit;
  } idx_ctl_t;

  // Token flags from the parser
  typedef struct packed {
    logic              name_valid;
    logic [CHAR_W-1:0] name_char;
    logic              field_done;
    logic              wild_done;
    logic              index_done;
    logic [ERR_W-1:0]  err;
  } tok_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: hw/rtl/pet_char_if.sv
// ----------------------------------------------------------------------------
// pet_char_if: character input channel
// Valid/ready channel that carries one path character and its last flag.
// ----------------------------------------------------------------------------
interface pet_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

FILE: hw/rtl/pet_token_if.sv
// ----------------------------------------------------------------------------
// pet_token_if: token output channel
// Valid/ready channel that carries one tokenizer result per character.
// ----------------------------------------------------------------------------
interface pet_token_if;
  logic        valid;
  logic        ready;
  logic        name_char_valid;
  logic [7:0]  name_char;
  logic        field_step_done;
  logic        wildcard_step_done;
  logic        index_step_done;
  logic [31:0] index_value;
  logic        index_saturated;
  logic [3:0]  error_code;
  logic        path_end;

  modport source (output valid, output name_char_valid, output name_char,
                  output field_step_done, output wildcard_step_done,
                  output index_step_done, output index_value,
                  output index_saturated, output error_code, output path_end,
                  input ready);
  modport sink   (input valid, input name_char_valid, input name_char,
                  input field_step_done, input wildcard_step_done,
                  input index_step_done, input index_value,
                  input index_saturated, input error_code, input path_end,
                  output ready);
endinterface

FILE: hw/rtl/path_expression_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// path_expression_tokenizer_unit: streaming path expression tokenizer
// Takes one path character per transfer and gives one token result for it.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Carries                                  Transfer when
//  ---------  ---  ---------------------------------------  ----------------
//  char_ch    in   char_in, last_char                       valid && ready
//  token_ch   out  name char, step done flags, index,       valid && ready
//                  error code, path end
//
//  One character enters per cycle while char_ch.ready is high. Its result passes
//  through the input register, then the result register, onto token_ch and
//  leaves at an edge with ready high. The parse state updates as a character leaves the
//  input register. rst (synchronous) empties both registers and returns the
//  parser to expecting '$'. A stall on token_ch holds the result register; the
//  input register still fills, so char_ch drops ready only when both are full.
//
module path_expression_tokenizer_unit #(
  parameter int INDEX_BITS = pet_pkg::DEFAULT_INDEX_BITS
) (
  input logic           clk,
  input logic           rst,
  pet_char_if.sink      char_ch,
  pet_token_if.source   token_ch
);

  // Input register
  logic                       in_valid;
  logic [pet_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  // Parse state
  logic [pet_pkg::MODE_W-1:0] mode;
  logic                       quote_is_double;
  logic [INDEX_BITS-1:0]      index_accum;
  logic                       accum_saturated;

  // Step logic outputs
  logic [pet_pkg::MODE_W-1:0] mode_next;
  logic                       quote_load;
  pet_pkg::idx_ctl_t          idx_ctl;
  pet_pkg::tok_t              tok;
  logic [INDEX_BITS-1:0]      index_accum_next;
  logic                       accum_saturated_next;

  // Result register
  logic                         out_valid;
  pet_pkg::tok_t                out_tok;
  logic [pet_pkg::OUT_INDEX_W-1:0] out_index;
  logic                         out_sat;
  logic                         out_last;

  logic out_free;
  logic advance;

  // The result register frees up when empty or when its transfer happens
  assign out_free     = !out_valid || token_ch.ready;
  assign advance      = in_valid && out_free;
  assign char_ch.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_ch.ready) begin
      in_valid <= char_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ch.ready && char_ch.valid) begin
      in_char <= char_ch.char_in;
      in_last <= char_ch.last_char;
    end
  end

  pet_parse u_parse (
    .mode            (mode),
    .quote_is_double (quote_is_double),
    .char_in         (in_char),
    .last_char       (in_last),
    .mode_next       (mode_next),
    .quote_load      (quote_load),
    .idx_ctl         (idx_ctl),
    .tok             (tok)
  );

  pet_index #(
    .INDEX_BITS (INDEX_BITS)
  ) u_index (
    .accum          (index_accum),
    .saturated      (accum_saturated),
    .ctl            (idx_ctl),
    .accum_next     (index_accum_next),
    .saturated_next (accum_saturated_next)
  );

  // Advance the parse state once per character, as it moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= pet_pkg::M_DOLLAR;
      quote_is_double <= 1'b0;
      index_accum     <= '0;
      accum_saturated <= 1'b0;
    end else if (advance) begin
      mode            <= mode_next;
      index_accum     <= index_accum_next;
      accum_saturated <= accum_saturated_next;
      if (quote_load) quote_is_double <= (in_char == pet_pkg::CH_DQUOTE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // Index fields are zero unless an index step finishes on this character
  always_ff @(posedge clk) begin
    if (advance) begin
      out_tok   <= tok;
      out_index <= tok.index_done ? pet_pkg::OUT_INDEX_W'(index_accum_next) : '0;
      out_sat   <= tok.index_done && accum_saturated_next;
      out_last  <= in_last;
    end
  end

  assign token_ch.valid              = out_valid;
  assign token_ch.name_char_valid    = out_tok.name_valid;
  assign token_ch.name_char          = out_tok.name_char;
  assign token_ch.field_step_done    = out_tok.field_done;
  assign token_ch.wildcard_step_done = out_tok.wild_done;
  assign token_ch.index_step_done    = out_tok.index_done;
  assign token_ch.index_value        = out_index;
  assign token_ch.index_saturated    = out_sat;
  assign token_ch.error_code         = out_tok.err;
  assign token_ch.path_end           = out_last;

endmodule

FILE: hw/rtl/pet_parse.sv
// ----------------------------------------------------------------------------
// pet_parse: per-character parse step
// Next parse mode, escape decoding, step completion and error detection.
// ----------------------------------------------------------------------------
module pet_parse (
  input  logic [pet_pkg::MODE_W-1:0] mode,
  input  logic                       quote_is_double,
  input  logic [pet_pkg::CHAR_W-1:0] char_in,
  input  logic                       last_char,
  output logic [pet_pkg::MODE_W-1:0] mode_next,
  output logic                       quote_load,
  output pet_pkg::idx_ctl_t          idx_ctl,
  output pet_pkg::tok_t              tok
);

  logic [pet_pkg::MODE_W-1:0] step_mode;
  logic [pet_pkg::ERR_W-1:0]  err;
  logic [pet_pkg::ERR_W-1:0]  end_err;
  logic [pet_pkg::CHAR_W-1:0] quote_ch;
  logic [pet_pkg::CHAR_W-1:0] nch;
  logic                       nvalid;
  logic                       fdone;
  logic                       wdone;
  logic                       idone;
  logic                       dig;
  logic                       ident_start;
  logic                       ident_char;

  assign dig         = pet_pkg::is_digit(char_in);
  assign ident_start = pet_pkg::is_alpha(char_in) || char_in == pet_pkg::CH_UNDER;
  assign ident_char  = ident_start || dig;
  assign quote_ch    = quote_is_double ? pet_pkg::CH_DQUOTE : pet_pkg::CH_SQUOTE;

  always_comb begin
    step_mode     = mode;
    err           = pet_pkg::E_OK;
    nvalid        = 1'b0;
    nch           = '0;
    fdone         = 1'b0;
    wdone         = 1'b0;
    idone         = 1'b0;
    quote_load    = 1'b0;
    idx_ctl.start = 1'b0;
    idx_ctl.add   = 1'b0;
    idx_ctl.digit = pet_pkg::DIGIT_W'(char_in - pet_pkg::CH_ZERO);
    case (mode)
      pet_pkg::M_DOLLAR: begin
        if (char_in == pet_pkg::CH_DOLLAR) step_mode = pet_pkg::M_STEP;
        else err = pet_pkg::E_NO_DOLLAR;
      end
      pet_pkg::M_STEP: begin
        if (char_in == pet_pkg::CH_DOT) step_mode = pet_pkg::M_DOT_FIRST;
        else if (char_in == pet_pkg::CH_LBR) step_mode = pet_pkg::M_BR_OPEN;
        else err = pet_pkg::E_BAD_SYNTAX;
      end
      pet_pkg::M_DOT_FIRST: begin
        if (ident_start) begin
          nvalid    = 1'b1;
          nch       = char_in;
          step_mode = pet_pkg::M_DOT_REST;
        end else begin
          err = pet_pkg::E_BAD_DOT;
        end
      end
      pet_pkg::M_DOT_REST: begin
        if (ident_char) begin
          nvalid = 1'b1;
          nch    = char_in;
        end else if (char_in == pet_pkg::CH_DOT) begin
          fdone     = 1'b1;
          step_mode = pet_pkg::M_DOT_FIRST;
        end else if (char_in == pet_pkg::CH_LBR) begin
          fdone     = 1'b1;
          step_mode = pet_pkg::M_BR_OPEN;
        end else begin
          err = pet_pkg::E_BAD_SYNTAX;
        end
      end
      pet_pkg::M_BR_OPEN: begin
        if (char_in == pet_pkg::CH_STAR) begin
          step_mode = pet_pkg::M_WILD_CLOSE;
        end else if (char_in == pet_pkg::CH_DQUOTE || char_in == pet_pkg::CH_SQUOTE) begin
          quote_load = 1'b1;
          step_mode  = pet_pkg::M_QUOTED;
        end else if (dig) begin
          idx_ctl.start = 1'b1;
          idx_ctl.add   = 1'b1;
          step_mode     = pet_pkg::M_INDEX;
        end else begin
          err = pet_pkg::E_BAD_BRACKET;
        end
      end
      pet_pkg::M_WILD_CLOSE: begin
        if (char_in == pet_pkg::CH_RBR) begin
          wdone     = 1'b1;
          step_mode = pet_pkg::M_STEP;
        end else begin
          err = pet_pkg::E_BAD_WILD;
        end
      end
      pet_pkg::M_QUOTED: begin
        if (char_in == quote_ch) begin
          step_mode = pet_pkg::M_QUOTE_CLOSE;
        end else if (char_in == pet_pkg::CH_BSLASH) begin
          step_mode = pet_pkg::M_QUOTED_ESC;
        end else begin
          nvalid = 1'b1;
          nch    = char_in;
        end
      end
      pet_pkg::M_QUOTED_ESC: begin
        nvalid    = 1'b1;
        step_mode = pet_pkg::M_QUOTED;
        if (char_in == pet_pkg::CH_BSLASH || char_in == pet_pkg::CH_DQUOTE ||
            char_in == pet_pkg::CH_SQUOTE || char_in == pet_pkg::CH_SLASH) begin
          nch = char_in;
        end else if (char_in == pet_pkg::CH_LOW_N) begin
          nch = pet_pkg::CH_LF;
        end else if (char_in == pet_pkg::CH_LOW_R) begin
          nch = pet_pkg::CH_CR;
        end else if (char_in == pet_pkg::CH_LOW_T) begin
          nch = pet_pkg::CH_TAB;
        end else begin
          nvalid = 1'b0;
          err    = pet_pkg::E_BAD_ESC;
        end
      end
      pet_pkg::M_QUOTE_CLOSE: begin
        if (char_in == pet_pkg::CH_RBR) begin
          fdone     = 1'b1;
          step_mode = pet_pkg::M_STEP;
        end else begin
          err = pet_pkg::E_QUOTE_CLOSE;
        end
      end
      pet_pkg::M_INDEX: begin
        if (dig) begin
          idx_ctl.add = 1'b1;
        end else if (char_in == pet_pkg::CH_RBR) begin
          idone     = 1'b1;
          step_mode = pet_pkg::M_STEP;
        end else begin
          err = pet_pkg::E_INDEX_CLOSE;
        end
      end
      default: begin
        step_mode = pet_pkg::M_SWALLOW;
      end
    endcase
    if (err != pet_pkg::E_OK) step_mode = pet_pkg::M_SWALLOW;
  end

  // End of path: close an open dot field, flag any other open step
  always_comb begin
    end_err = pet_pkg::E_OK;
    if (last_char) begin
      case (step_mode)
        pet_pkg::M_DOT_FIRST:   end_err = pet_pkg::E_BAD_DOT;
        pet_pkg::M_BR_OPEN:     end_err = pet_pkg::E_OPEN_BR;
        pet_pkg::M_WILD_CLOSE:  end_err = pet_pkg::E_BAD_WILD;
        pet_pkg::M_QUOTED_ESC:  end_err = pet_pkg::E_ESC_END;
        pet_pkg::M_QUOTED:      end_err = pet_pkg::E_OPEN_QUOTE;
        pet_pkg::M_QUOTE_CLOSE: end_err = pet_pkg::E_QUOTE_CLOSE;
        pet_pkg::M_INDEX:       end_err = pet_pkg::E_INDEX_CLOSE;
        default:                end_err = pet_pkg::E_OK;
      endcase
    end
  end

  always_comb begin
    tok.err = (err != pet_pkg::E_OK) ? err : end_err;
    if (tok.err != pet_pkg::E_OK) begin
      tok.name_valid = 1'b0;
      tok.name_char  = '0;
      tok.field_done = 1'b0;
      tok.wild_done  = 1'b0;
      tok.index_done = 1'b0;
    end else begin
      tok.name_valid = nvalid;
      tok.name_char  = nvalid ? nch : '0;
      tok.field_done = fdone || (last_char && step_mode == pet_pkg::M_DOT_REST);
      tok.wild_done  = wdone;
      tok.index_done = idone;
    end
    mode_next = last_char ? pet_pkg::M_DOLLAR : step_mode;
  end

endmodule

FILE: hw/rtl/pet_index.sv
// ----------------------------------------------------------------------------
// pet_index: decimal index accumulator step
// Fold one digit into the index as acc*10+d, clamp at all ones on overflow.
// ----------------------------------------------------------------------------
module pet_index #(
  parameter int INDEX_BITS = pet_pkg::DEFAULT_INDEX_BITS
) (
  input  logic [INDEX_BITS-1:0] accum,
  input  logic                  saturated,
  input  pet_pkg::idx_ctl_t     ctl,
  output logic [INDEX_BITS-1:0] accum_next,
  output logic                  saturated_next
);

  localparam int PROD_W = INDEX_BITS + pet_pkg::DIGIT_W;

  logic [PROD_W-1:0] base;
  logic [PROD_W-1:0] prod;
  logic              base_sat;
  logic              ovf;

  assign base     = ctl.start ? '0 : PROD_W'(accum);
  assign base_sat = ctl.start ? 1'b0 : saturated;
  // acc*10 as two shifts, then the digit
  assign prod = (base << 3) + (base << 1) + PROD_W'(ctl.digit);
  assign ovf  = prod[PROD_W-1:INDEX_BITS] != '0;

  always_comb begin
    accum_next     = accum;
    saturated_next = saturated;
    if (ctl.add) begin
      if (ovf) begin
        accum_next     = '1;
        saturated_next = 1'b1;
      end else begin
        accum_next     = prod[INDEX_BITS-1:0];
        saturated_next = base_sat;
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the path expression tokenizer
// Feeds path text one character per transfer and predicts one token result
// per character in step with the bench. Runs a few hand-picked paths, then
// random paths: mostly well-formed, some truncated, corrupted or noise. Both
// channels idle at random, and results are checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEMS_TARGET = 950;
  localparam int          LIMIT_CYCLES = 400_000;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          IDX_BITS     = pet_pkg::DEFAULT_INDEX_BITS;
  localparam logic [63:0] IDX_MAX      = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - IDX_BITS);

  // One character of path text, plus a mark to hold it until the block drains.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic       drain;
  } path_char_t;

  // One token result, laid out as the token channel carries it.
  typedef struct packed {
    logic        name_valid;
    logic [7:0]  name;
    logic        field_done;
    logic        wild_done;
    logic        index_done;
    logic [31:0] index;
    logic        index_sat;
    logic [3:0]  err;
    logic        path_end;
  } token_t;

  logic clk;
  logic rst;

  pet_char_if  char_ch ();
  pet_token_if token_ch ();

  path_expression_tokenizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .char_ch  (char_ch),
    .token_ch (token_ch)
  );

  // Stimulus and expected results
  path_char_t path_chars[$];
  token_t     predicted_tokens[$];
  logic [7:0] path_buf[$];

  // Tokenizer state as the bench tracks it
  logic [pet_pkg::MODE_W-1:0] mode_p;
  logic                       quote_dq;
  logic [63:0]                idx_acc;
  logic                       idx_sat;

  // Handshake bookkeeping
  logic char_took;
  int   gap_left, tx_calm, stall_left, rx_calm, cycle_cnt;

  // Run statistics
  int          fail_cnt, paths_built, chars_sent, results_seen;
  int          name_cnt, field_cnt, index_cnt, sat_cnt, wild_cnt;
  logic [15:0] err_seen;

  localparam logic [7:0] ESC_CHARS[7] = '{pet_pkg::CH_BSLASH, pet_pkg::CH_DQUOTE,
                                          pet_pkg::CH_SQUOTE, pet_pkg::CH_SLASH,
                                          pet_pkg::CH_LOW_N, pet_pkg::CH_LOW_R,
                                          pet_pkg::CH_LOW_T};

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic letter_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic decimal_char(input logic [7:0] c);
    return c >= pet_pkg::CH_ZERO && c <= pet_pkg::CH_ZERO + 8'd9;
  endfunction

  // Fold one decimal digit in; clamp at the largest index and flag it.
  function automatic void add_digit(input logic [7:0] d);
    if (idx_acc > (IDX_MAX - 64'(d)) / pet_pkg::RADIX) begin
      idx_acc = IDX_MAX;
      idx_sat = 1'b1;
    end else begin
      idx_acc = idx_acc * pet_pkg::RADIX + 64'(d);
    end
  endfunction

  // Advance the tracked state by one character and return its token.
  function automatic token_t tokenize_char(input logic [7:0] c, input logic is_last);
    token_t     r;
    logic [7:0] q;
    r = '0;
    q = quote_dq ? pet_pkg::CH_DQUOTE : pet_pkg::CH_SQUOTE;
    case (mode_p)
      pet_pkg::M_DOLLAR: begin
        if (c == pet_pkg::CH_DOLLAR) mode_p = pet_pkg::M_STEP;
        else r.err = pet_pkg::E_NO_DOLLAR;
      end
      pet_pkg::M_STEP: begin
        if (c == pet_pkg::CH_DOT) mode_p = pet_pkg::M_DOT_FIRST;
        else if (c == pet_pkg::CH_LBR) mode_p = pet_pkg::M_BR_OPEN;
        else r.err = pet_pkg::E_BAD_SYNTAX;
      end
      pet_pkg::M_DOT_FIRST: begin
        if (letter_char(c) || c == pet_pkg::CH_UNDER) begin
          r.name_valid = 1'b1;
          r.name = c;
          mode_p = pet_pkg::M_DOT_REST;
        end else begin
          r.err = pet_pkg::E_BAD_DOT;
        end
      end
      pet_pkg::M_DOT_REST: begin
        if (letter_char(c) || decimal_char(c) || c == pet_pkg::CH_UNDER) begin
          r.name_valid = 1'b1;
          r.name = c;
        end else if (c == pet_pkg::CH_DOT) begin
          r.field_done = 1'b1;
          mode_p = pet_pkg::M_DOT_FIRST;
        end else if (c == pet_pkg::CH_LBR) begin
          r.field_done = 1'b1;
          mode_p = pet_pkg::M_BR_OPEN;
        end else begin
          r.err = pet_pkg::E_BAD_SYNTAX;
        end
      end
      pet_pkg::M_BR_OPEN: begin
        if (c == pet_pkg::CH_STAR) begin
          mode_p = pet_pkg::M_WILD_CLOSE;
        end else if (c == pet_pkg::CH_DQUOTE || c == pet_pkg::CH_SQUOTE) begin
          quote_dq = (c == pet_pkg::CH_DQUOTE);
          mode_p = pet_pkg::M_QUOTED;
        end else if (decimal_char(c)) begin
          idx_acc = '0;
          idx_sat = 1'b0;
          add_digit(c - pet_pkg::CH_ZERO);
          mode_p = pet_pkg::M_INDEX;
        end else begin
          r.err = pet_pkg::E_BAD_BRACKET;
        end
      end
      pet_pkg::M_WILD_CLOSE: begin
        if (c == pet_pkg::CH_RBR) begin
          r.wild_done = 1'b1;
          mode_p = pet_pkg::M_STEP;
        end else begin
          r.err = pet_pkg::E_BAD_WILD;
        end
      end
      pet_pkg::M_QUOTED: begin
        if (c == q) begin
          mode_p = pet_pkg::M_QUOTE_CLOSE;
        end else if (c == pet_pkg::CH_BSLASH) begin
          mode_p = pet_pkg::M_QUOTED_ESC;
        end else begin
          r.name_valid = 1'b1;
          r.name = c;
        end
      end
      pet_pkg::M_QUOTED_ESC: begin
        if (c == pet_pkg::CH_BSLASH || c == pet_pkg::CH_DQUOTE ||
            c == pet_pkg::CH_SQUOTE || c == pet_pkg::CH_SLASH) r.name = c;
        else if (c == pet_pkg::CH_LOW_N) r.name = pet_pkg::CH_LF;
        else if (c == pet_pkg::CH_LOW_R) r.name = pet_pkg::CH_CR;
        else if (c == pet_pkg::CH_LOW_T) r.name = pet_pkg::CH_TAB;
        else r.err = pet_pkg::E_BAD_ESC;
        if (r.err == pet_pkg::E_OK) begin
          r.name_valid = 1'b1;
          mode_p = pet_pkg::M_QUOTED;
        end
      end
      pet_pkg::M_QUOTE_CLOSE: begin
        if (c == pet_pkg::CH_RBR) begin
          r.field_done = 1'b1;
          mode_p = pet_pkg::M_STEP;
        end else begin
          r.err = pet_pkg::E_QUOTE_CLOSE;
        end
      end
      pet_pkg::M_INDEX: begin
        if (decimal_char(c)) begin
          add_digit(c - pet_pkg::CH_ZERO);
        end else if (c == pet_pkg::CH_RBR) begin
          r.index_done = 1'b1;
          mode_p = pet_pkg::M_STEP;
        end else begin
          r.err = pet_pkg::E_INDEX_CLOSE;
        end
      end
      default: mode_p = pet_pkg::M_SWALLOW;
    endcase

    if (r.err != pet_pkg::E_OK) mode_p = pet_pkg::M_SWALLOW;

    // The final character closes a dot field or reports the open step.
    if (is_last) begin
      case (mode_p)
        pet_pkg::M_DOT_REST:    r.field_done = 1'b1;
        pet_pkg::M_DOT_FIRST:   r.err = pet_pkg::E_BAD_DOT;
        pet_pkg::M_BR_OPEN:     r.err = pet_pkg::E_OPEN_BR;
        pet_pkg::M_WILD_CLOSE:  r.err = pet_pkg::E_BAD_WILD;
        pet_pkg::M_QUOTED_ESC:  r.err = pet_pkg::E_ESC_END;
        pet_pkg::M_QUOTED:      r.err = pet_pkg::E_OPEN_QUOTE;
        pet_pkg::M_QUOTE_CLOSE: r.err = pet_pkg::E_QUOTE_CLOSE;
        pet_pkg::M_INDEX:       r.err = pet_pkg::E_INDEX_CLOSE;
        default: ;
      endcase
      mode_p = pet_pkg::M_DOLLAR;
    end

    // An error item carries no token.
    if (r.err != pet_pkg::E_OK) begin
      r.name_valid = 1'b0;
      r.field_done = 1'b0;
      r.wild_done  = 1'b0;
      r.index_done = 1'b0;
    end
    if (!r.name_valid) r.name = '0;
    if (r.index_done) begin
      r.index     = idx_acc[31:0];
      r.index_sat = idx_sat;
    end
    r.path_end = is_last;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Path generation
  // --------------------------------------------------------------------------
  // Append one byte to the path being built.
  function automatic void add_byte(input logic [7:0] b);
    path_buf.insert(path_buf.size(), b);
  endfunction

  function automatic logic [7:0] ident_pick(input bit head);
    int unsigned r;
    r = head ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return pet_pkg::CH_UNDER;
    return pet_pkg::CH_ZERO + 8'(r - 53);
  endfunction

  // Move path_buf into the pending queue; mark its final character.
  function automatic void emit_path(input bit drain);
    path_char_t pc;
    foreach (path_buf[i]) begin
      pc.ch      = path_buf[i];
      pc.is_last = (i == path_buf.size() - 1);
      pc.drain   = drain && (i == 0);
      path_chars.insert(path_chars.size(), pc);
    end
    paths_built++;
  endfunction

  function automatic void queue_text(input string s);
    path_buf.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    emit_path(1'b0);
  endfunction

  // Build a well-formed path: '$' and up to four random steps.
  function automatic void build_path();
    logic [7:0] q, c;
    int         n;
    path_buf.delete();
    add_byte(pet_pkg::CH_DOLLAR);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: begin
          add_byte(pet_pkg::CH_DOT);
          add_byte(ident_pick(1'b1));
          repeat ($urandom_range(0, 5)) add_byte(ident_pick(1'b0));
        end
        1: begin
          q = $urandom_range(0, 1) ? pet_pkg::CH_DQUOTE : pet_pkg::CH_SQUOTE;
          add_byte(pet_pkg::CH_LBR);
          add_byte(q);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
              add_byte(pet_pkg::CH_BSLASH);
              add_byte(ESC_CHARS[$urandom_range(0, 6)]);
            end else begin
              do c = 8'($urandom_range(0, 255)); while (c == q || c == pet_pkg::CH_BSLASH);
              add_byte(c);
            end
          end
          add_byte(q);
          add_byte(pet_pkg::CH_RBR);
        end
        2: begin
          // Mostly short indexes; some long enough to clamp.
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
          add_byte(pet_pkg::CH_LBR);
          repeat (n) add_byte(pet_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          add_byte(pet_pkg::CH_RBR);
        end
        default: begin
          add_byte(pet_pkg::CH_LBR);
          add_byte(pet_pkg::CH_STAR);
          add_byte(pet_pkg::CH_RBR);
        end
      endcase
    end
  endfunction

  // Break a built path: cut it short, overwrite or insert a byte, or replace
  // it with noise.
  function automatic void break_path();
    int         pos, cut;
    logic [7:0] syn[9];
    syn = '{pet_pkg::CH_DOT, pet_pkg::CH_LBR, pet_pkg::CH_RBR, pet_pkg::CH_STAR,
            pet_pkg::CH_DQUOTE, pet_pkg::CH_SQUOTE, pet_pkg::CH_BSLASH,
            pet_pkg::CH_DOLLAR, pet_pkg::CH_ZERO};
    pos = $urandom_range(0, path_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: begin
        if (path_buf.size() > 1) begin
          cut = $urandom_range(1, path_buf.size() - 1);
          while (path_buf.size() > cut) void'(path_buf.pop_back());
        end else begin
          path_buf[0] = 8'($urandom_range(0, 255));
        end
      end
      1: path_buf[pos] = 8'($urandom_range(0, 255));
      2: path_buf.insert(pos, $urandom_range(0, 1) ? syn[$urandom_range(0, 8)]
                                                   : 8'($urandom_range(0, 255)));
      default: begin
        path_buf.delete();
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic int pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, seen);
      fail_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: present the next character at the falling edge once the previous
  // one has transferred; hold it while ready is low.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : char_drive
    path_char_t nxt;
    if (rst) begin
      char_ch.valid     <= 1'b0;
      char_ch.char_in   <= '0;
      char_ch.last_char <= 1'b0;
    end else if (!char_ch.valid || char_took) begin
      if (gap_left > 0) begin
        // idle the channel for the chosen gap
        gap_left--;
        char_ch.valid <= 1'b0;
      end else if (path_chars.size() == 0 ||
                   (path_chars[0].drain && predicted_tokens.size() != 0)) begin
        // out of text, or hold until every pending token has come back
        char_ch.valid <= 1'b0;
      end else begin
        nxt = path_chars.pop_front();
        char_ch.char_in   <= nxt.ch;
        char_ch.last_char <= nxt.is_last;
        char_ch.valid     <= 1'b1;
        if (tx_calm > 0) begin
          tx_calm--;
          gap_left = 0;
        end else begin
          gap_left = pause_len();
          if ($urandom_range(0, 59) == 0) tx_calm = 50;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: drop ready for random stalls, with calm stretches in between.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      token_ch.ready <= 1'b0;
    end else begin
      token_ch.ready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        stall_left = pause_len();
        if ($urandom_range(0, 59) == 0) rx_calm = 50;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge check a token transfer against the oldest
  // prediction, then predict for a character transfer. Checking first keeps
  // a token from pairing with a prediction made in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : token_check
    token_t want;
    if (rst) begin
      char_took <= 1'b0;
    end else begin
      char_took <= char_ch.valid && char_ch.ready;
      if (token_ch.valid && token_ch.ready) begin
        if (predicted_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual err %0d end %0b",
                   $time, token_ch.error_code, token_ch.path_end);
          fail_cnt++;
        end else begin
          want = predicted_tokens.pop_front();
          results_seen++;
          check_field("name_char_valid", 32'(want.name_valid), 32'(token_ch.name_char_valid));
          check_field("name_char", 32'(want.name), 32'(token_ch.name_char));
          check_field("field_step_done", 32'(want.field_done), 32'(token_ch.field_step_done));
          check_field("wildcard_step_done", 32'(want.wild_done),
                      32'(token_ch.wildcard_step_done));
          check_field("index_step_done", 32'(want.index_done), 32'(token_ch.index_step_done));
          check_field("index_value", want.index, token_ch.index_value);
          check_field("index_saturated", 32'(want.index_sat), 32'(token_ch.index_saturated));
          check_field("error_code", 32'(want.err), 32'(token_ch.error_code));
          check_field("path_end", 32'(want.path_end), 32'(token_ch.path_end));
          err_seen[want.err] = 1'b1;
          name_cnt  += want.name_valid;
          field_cnt += want.field_done;
          wild_cnt  += want.wild_done;
          index_cnt += want.index_done;
          sat_cnt   += want.index_sat;
        end
      end
      if (char_ch.valid && char_ch.ready) begin
        predicted_tokens.insert(predicted_tokens.size(),
                                tokenize_char(char_ch.char_in, char_ch.last_char));
        chars_sent++;
      end
    end
  end

  // Watchdog: end the run once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d tokens outstanding", $time, cycle_cnt,
               predicted_tokens.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the text queue, reset, wait for every token, report.
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    char_ch.valid = 1'b0;
    char_ch.char_in = '0;
    char_ch.last_char = 1'b0;
    token_ch.ready = 1'b0;
    char_took = 1'b0;
    mode_p = pet_pkg::M_DOLLAR;
    quote_dq = 1'b0;
    idx_acc = '0;
    idx_sat = 1'b0;
    gap_left = 0; tx_calm = 0; stall_left = 0; rx_calm = 0; cycle_cnt = 0;
    fail_cnt = 0; paths_built = 0; chars_sent = 0; results_seen = 0;
    name_cnt = 0; field_cnt = 0; index_cnt = 0; sat_cnt = 0; wild_cnt = 0;
    err_seen = '0;

    // Directed: an all-ones byte where '$' belongs; dot fields closed by '.'
    // and '['; a wildcard; a single-quoted field holding '"' and an escaped
    // newline; an index one past the 32-bit range.
    path_buf.delete();
    add_byte(8'hFF);
    emit_path(1'b0);
    queue_text("$.a_Z9.b[*]");
    queue_text("$['\"\\n']");
    queue_text("$[4294967296]");

    // Random: hold the first random path until the directed part drains, and
    // now and then again later.
    build_path();
    emit_path(1'b1);
    while (path_chars.size() < ITEMS_TARGET) begin
      build_path();
      if ($urandom_range(0, 3) == 0) break_path();
      emit_path($urandom_range(0, 19) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (path_chars.size() != 0 || char_ch.valid || predicted_tokens.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d paths, %0d characters, %0d tokens; error codes seen (bit per code) %b",
             paths_built, chars_sent, results_seen, err_seen[11:0]);
    $display("Tokens: %0d name chars, %0d fields, %0d indexes (%0d clamped), %0d wildcards",
             name_cnt, field_cnt, index_cnt, sat_cnt, wild_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
